[sv/gha_pkg.sv]
package gha_pkg;

   // table geometry
   localparam int ENTRY_COUNT = 4096;
   localparam int GEN_BITS    = 12;
   localparam int MASK_BITS   = 32;

   localparam int SLOT_W = $clog2(ENTRY_COUNT);
   localparam int CNT_W  = $clog2(ENTRY_COUNT + 1);

   // port field widths
   localparam int CMD_W   = 3;
   localparam int INDEX_W = 12;
   localparam int GEN_W   = 12;
   localparam int MASK_W  = 32;
   localparam int TOTAL_W = 13;

   // command and result queue depths
   localparam int CQ_DEPTH = 2;
   localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
   localparam int RQ_DEPTH = 2;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   // command codes on the request port
   localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SETMASK = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESTORE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RESEED  = 3'd5;

   typedef enum logic [2:0] {
      OP_CREATE,
      OP_DESTROY,
      OP_QUERY,
      OP_SETMASK,
      OP_RESTORE,
      OP_RESEED,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STACK,
      ST_EXEC,
      ST_WALK
   } eng_state_type;

   typedef struct packed {
      op_type             op;
      logic               in_range;
      logic [SLOT_W-1:0]  idx;
      logic [GEN_W-1:0]   gen;
      logic [MASK_W-1:0]  mask;
   } cmd_entry_type;

   typedef struct packed {
      logic                 live;
      logic [GEN_BITS-1:0]  gen;
      logic [MASK_BITS-1:0] mask;
   } slot_word_type;

   typedef struct packed {
      logic                ok;
      logic [INDEX_W-1:0]  index;
      logic [GEN_W-1:0]    generation;
      logic                is_live;
      logic [MASK_W-1:0]   mask;
      logic [TOTAL_W-1:0]  live_total;
   } rsp_item_type;

   localparam slot_word_type CLEAR_WORD = '{live: 1'b0, gen: GEN_BITS'(1), mask: '0};

   // generation from the request field, zero stored as one
   function automatic logic [GEN_BITS-1:0] fix_gen(input logic [GEN_W-1:0] g);
      logic [GEN_BITS-1:0] v;
      v = GEN_BITS'(32'(g));
      return (v == '0) ? GEN_BITS'(1) : v;
   endfunction

   // advance a generation, skipping zero
   function automatic logic [GEN_BITS-1:0] bump_gen(input logic [GEN_BITS-1:0] g);
      logic [GEN_BITS-1:0] v;
      v = g + GEN_BITS'(1);
      return (v == '0) ? GEN_BITS'(1) : v;
   endfunction

   function automatic logic gen_match(input logic [GEN_BITS-1:0] stored,
                                      input logic [GEN_W-1:0] field);
      return 32'(stored) == 32'(field);
   endfunction

endpackage

[sv/generational_handle_allocator.sv]
// Channel   Handshake               Payload
// request   push / full             req_cmd, req_slot_index, req_slot_generation_in, req_mask_in
// result    empty / pop             rsp_ok, rsp_out_index, rsp_out_generation, rsp_is_live,
//                                   rsp_mask_out, rsp_live_total_out
//
// Destroy, query, set mask, restore, unknown commands and create from the high mark go from the
// idle state straight to execute; create from the recycle stack reads the stack before the slot.
// Reseed walks the slots below high_mark, highest first, with one slot-table read per slot on
// the single read port, then settles the last read and leaves the walk before executing.
// After reset a clearing pass writes all ENTRY_COUNT (4096) slots, one a cycle; requests
// queue up to the command queue depth meanwhile and execute afterwards.
// A full result queue stalls execution only; the command queue keeps accepting until full.
module generational_handle_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [gha_pkg::CMD_W-1:0]     req_cmd,
   input  logic [gha_pkg::INDEX_W-1:0]   req_slot_index,
   input  logic [gha_pkg::GEN_W-1:0]     req_slot_generation_in,
   input  logic [gha_pkg::MASK_W-1:0]    req_mask_in,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_ok,
   output logic [gha_pkg::INDEX_W-1:0]   rsp_out_index,
   output logic [gha_pkg::GEN_W-1:0]     rsp_out_generation,
   output logic                          rsp_is_live,
   output logic [gha_pkg::MASK_W-1:0]    rsp_mask_out,
   output logic [gha_pkg::TOTAL_W-1:0]   rsp_live_total_out
);
   import gha_pkg::*;

   logic            cq_valid;
   cmd_entry_type   cq_head;
   logic            cq_pop;
   logic            rsp_push;
   rsp_item_type    rsp_item;
   logic            rsp_space;
   rsp_item_type    rsp_head;

   gha_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .push                   (push),
      .full                   (full),
      .req_cmd                (req_cmd),
      .req_slot_index         (req_slot_index),
      .req_slot_generation_in (req_slot_generation_in),
      .req_mask_in            (req_mask_in),
      .head_valid             (cq_valid),
      .head                   (cq_head),
      .head_pop               (cq_pop)
   );

   gha_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (cq_valid),
      .head       (cq_head),
      .head_pop   (cq_pop),
      .rsp_push   (rsp_push),
      .rsp_item   (rsp_item),
      .rsp_space  (rsp_space)
   );

   gha_rsp_q u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (rsp_item),
      .space     (rsp_space),
      .empty     (empty),
      .pop       (pop),
      .head      (rsp_head)
   );

   assign rsp_ok             = rsp_head.ok;
   assign rsp_out_index      = rsp_head.index;
   assign rsp_out_generation = rsp_head.generation;
   assign rsp_is_live        = rsp_head.is_live;
   assign rsp_mask_out       = rsp_head.mask;
   assign rsp_live_total_out = rsp_head.live_total;

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> rsp_space)
      else $error("result written into a full result queue");

   a_pop_has_cmd: assert property (@(posedge clock) disable iff (reset)
      cq_pop |-> cq_valid)
      else $error("command taken from an empty command queue");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> 32'(rsp_live_total_out) <= ENTRY_COUNT)
      else $error("live total beyond table size");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_ok) |-> (rsp_out_index == '0 && rsp_is_live == 1'b0
                               && rsp_mask_out == '0))
      else $error("failed request carries a handle");

endmodule

[sv/gha_front.sv]
module gha_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [gha_pkg::CMD_W-1:0]     req_cmd,
   input  logic [gha_pkg::INDEX_W-1:0]   req_slot_index,
   input  logic [gha_pkg::GEN_W-1:0]     req_slot_generation_in,
   input  logic [gha_pkg::MASK_W-1:0]    req_mask_in,
   output logic                          head_valid,
   output gha_pkg::cmd_entry_type        head,
   input  logic                          head_pop
);
   import gha_pkg::*;

   cmd_entry_type          q_ff [CQ_DEPTH];
   cmd_entry_type          entry_in;
   logic [CQ_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                   accept;
   logic                   take;

   // classify the request
   always_comb begin
      entry_in.in_range = 32'(req_slot_index) < ENTRY_COUNT;
      entry_in.idx      = SLOT_W'(req_slot_index);
      entry_in.gen      = req_slot_generation_in;
      entry_in.mask     = req_mask_in;
      case (req_cmd)
         CMD_CREATE:  entry_in.op = OP_CREATE;
         CMD_DESTROY: entry_in.op = OP_DESTROY;
         CMD_QUERY:   entry_in.op = OP_QUERY;
         CMD_SETMASK: entry_in.op = OP_SETMASK;
         CMD_RESTORE: entry_in.op = OP_RESTORE;
         CMD_RESEED:  entry_in.op = OP_RESEED;
         default:     entry_in.op = OP_NONE;
      endcase
   end

   assign full       = cnt_ff == CQ_CNT_W'(CQ_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head       = q_ff[rd_ptr_ff];
   assign accept     = push && !full;
   assign take       = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_ff + CQ_PTR_W'(1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_ff + CQ_PTR_W'(1);
      end
      if (accept && !take) begin
         cnt_in = cnt_ff + CQ_CNT_W'(1);
      end else if (take && !accept) begin
         cnt_in = cnt_ff - CQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

[sv/gha_back.sv]
module gha_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  gha_pkg::cmd_entry_type  head,
   output logic                    head_pop,
   output logic                    rsp_push,
   output gha_pkg::rsp_item_type   rsp_item,
   input  logic                    rsp_space
);
   import gha_pkg::*;

   // slot table and recycle stack
   slot_word_type       slot_mem [ENTRY_COUNT];
   logic [SLOT_W-1:0]   stack_mem [ENTRY_COUNT];
   slot_word_type       slot_rd_ff;
   logic [SLOT_W-1:0]   stack_rd_ff;

   logic                slot_re, slot_we;
   logic [SLOT_W-1:0]   slot_ra, slot_wa;
   slot_word_type       slot_wd;
   logic                stk_re, stk_we;
   logic [SLOT_W-1:0]   stk_ra, stk_wa, stk_wd;

   eng_state_type       state_ff, state_in;
   cmd_entry_type       cur_ff, cur_in;
   logic [SLOT_W-1:0]   clr_ff, clr_in;
   logic [SLOT_W-1:0]   addr_ff, addr_in;
   logic                found_ff, found_in;
   logic [CNT_W-1:0]    depth_ff, depth_in;
   logic [CNT_W-1:0]    high_ff, high_in;
   logic [CNT_W-1:0]    live_ff, live_in;
   logic [CNT_W-1:0]    walk_ff, walk_in;
   logic                pend_ff, pend_in;
   logic [SLOT_W-1:0]   pend_addr_ff, pend_addr_in;

   logic [CNT_W-1:0]    depth_dec, walk_dec, addr_plus, live_up, live_down;
   logic                depth_below, high_below, hit;
   logic [GEN_BITS-1:0] restore_gen;

   assign depth_dec   = depth_ff - CNT_W'(1);
   assign walk_dec    = walk_ff - CNT_W'(1);
   assign addr_plus   = CNT_W'(addr_ff) + CNT_W'(1);
   assign live_up     = (live_ff < CNT_W'(ENTRY_COUNT)) ? live_ff + CNT_W'(1) : live_ff;
   assign live_down   = (live_ff != '0) ? live_ff - CNT_W'(1) : live_ff;
   assign depth_below = depth_ff < CNT_W'(ENTRY_COUNT);
   assign high_below  = high_ff < CNT_W'(ENTRY_COUNT);
   assign hit         = cur_ff.in_range && slot_rd_ff.live && gen_match(slot_rd_ff.gen, cur_ff.gen);
   assign restore_gen = fix_gen(cur_ff.gen);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      found_in     = found_ff;
      depth_in     = depth_ff;
      high_in      = high_ff;
      live_in      = live_ff;
      walk_in      = walk_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      head_pop     = 1'b0;
      rsp_push     = 1'b0;
      rsp_item     = '0;
      slot_re      = 1'b0;
      slot_ra      = addr_ff;
      slot_we      = 1'b0;
      slot_wa      = addr_ff;
      slot_wd      = slot_rd_ff;
      stk_re       = 1'b0;
      stk_ra       = depth_dec[SLOT_W-1:0];
      stk_we       = 1'b0;
      stk_wa       = depth_ff[SLOT_W-1:0];
      stk_wd       = addr_ff;

      case (state_ff)
         ST_CLEAR: begin
            slot_we = 1'b1;
            slot_wa = clr_ff;
            slot_wd = CLEAR_WORD;
            if (clr_ff == SLOT_W'(ENTRY_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + SLOT_W'(1);
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               cur_in   = head;
               addr_in  = head.idx;
               found_in = 1'b0;
               case (head.op)
                  OP_CREATE: begin
                     if (depth_ff != '0) begin
                        stk_re   = 1'b1;
                        depth_in = depth_dec;
                        found_in = 1'b1;
                        state_in = ST_STACK;
                     end else if (high_below) begin
                        addr_in  = high_ff[SLOT_W-1:0];
                        slot_re  = 1'b1;
                        slot_ra  = high_ff[SLOT_W-1:0];
                        high_in  = high_ff + CNT_W'(1);
                        found_in = 1'b1;
                        state_in = ST_EXEC;
                     end else begin
                        state_in = ST_EXEC;
                     end
                  end
                  OP_DESTROY, OP_QUERY, OP_SETMASK: begin
                     slot_re  = 1'b1;
                     slot_ra  = head.idx;
                     state_in = ST_EXEC;
                  end
                  OP_RESEED: begin
                     depth_in = '0;
                     live_in  = '0;
                     walk_in  = high_ff;
                     pend_in  = 1'b0;
                     state_in = ST_WALK;
                  end
                  default: state_in = ST_EXEC;
               endcase
            end
         end
         ST_STACK: begin
            addr_in  = stack_rd_ff;
            slot_re  = 1'b1;
            slot_ra  = stack_rd_ff;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (cur_ff.op)
               OP_CREATE: begin
                  if (found_ff) begin
                     slot_we                = 1'b1;
                     slot_wd                = '{live: 1'b1, gen: slot_rd_ff.gen, mask: '0};
                     live_in                = live_up;
                     rsp_item.ok            = 1'b1;
                     rsp_item.index         = INDEX_W'(addr_ff);
                     rsp_item.generation    = GEN_W'(slot_rd_ff.gen);
                  end
               end
               OP_DESTROY: begin
                  if (hit) begin
                     slot_we = 1'b1;
                     slot_wd = '{live: 1'b0, gen: bump_gen(slot_rd_ff.gen), mask: '0};
                     if (depth_below) begin
                        stk_we   = 1'b1;
                        depth_in = depth_ff + CNT_W'(1);
                     end
                     live_in     = live_down;
                     rsp_item.ok = 1'b1;
                  end
               end
               OP_QUERY: begin
                  if (hit) begin
                     rsp_item.ok      = 1'b1;
                     rsp_item.is_live = 1'b1;
                     rsp_item.mask    = MASK_W'(slot_rd_ff.mask);
                  end
               end
               OP_SETMASK: begin
                  if (hit) begin
                     slot_we      = 1'b1;
                     slot_wd.mask = MASK_BITS'(cur_ff.mask);
                     rsp_item.ok  = 1'b1;
                  end
               end
               OP_RESTORE: begin
                  if (cur_ff.in_range) begin
                     slot_we = 1'b1;
                     slot_wd = '{live: 1'b1, gen: restore_gen, mask: '0};
                     if (addr_plus > high_ff) begin
                        high_in = addr_plus;
                     end
                     rsp_item.ok         = 1'b1;
                     rsp_item.index      = INDEX_W'(addr_ff);
                     rsp_item.generation = GEN_W'(restore_gen);
                  end
               end
               OP_RESEED: rsp_item.ok = 1'b1;
               default: ;
            endcase
            rsp_item.live_total = TOTAL_W'(live_in);
            // hold the item until the result queue has room
            if (rsp_space) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end else begin
               slot_we  = 1'b0;
               stk_we   = 1'b0;
               depth_in = depth_ff;
               live_in  = live_ff;
               high_in  = high_ff;
            end
         end
         ST_WALK: begin
            // settle the slot read last cycle, highest index first
            if (pend_ff) begin
               if (slot_rd_ff.live) begin
                  live_in = live_up;
               end else if (depth_below) begin
                  stk_we   = 1'b1;
                  stk_wd   = pend_addr_ff;
                  depth_in = depth_ff + CNT_W'(1);
               end
            end
            if (walk_ff != '0) begin
               slot_re      = 1'b1;
               slot_ra      = walk_dec[SLOT_W-1:0];
               walk_in      = walk_dec;
               pend_in      = 1'b1;
               pend_addr_in = walk_dec[SLOT_W-1:0];
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_EXEC;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         depth_ff <= '0;
         high_ff  <= '0;
         live_ff  <= '0;
         walk_ff  <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         depth_ff <= depth_in;
         high_ff  <= high_in;
         live_ff  <= live_in;
         walk_ff  <= walk_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      addr_ff      <= addr_in;
      pend_addr_ff <= pend_addr_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      if (slot_re) begin
         slot_rd_ff <= slot_mem[slot_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_wa] <= stk_wd;
      end
      if (stk_re) begin
         stack_rd_ff <= stack_mem[stk_ra];
      end
   end

endmodule

[sv/gha_rsp_q.sv]
module gha_rsp_q (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gha_pkg::rsp_item_type  push_item,
   output logic                   space,
   output logic                   empty,
   input  logic                   pop,
   output gha_pkg::rsp_item_type  head
);
   import gha_pkg::*;

   rsp_item_type         q_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                 put;
   logic                 take;

   assign space = cnt_ff != RQ_CNT_W'(RQ_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = q_ff[rd_ptr_ff];
   assign put   = push && space;
   assign take  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (put) begin
         wr_ptr_in = (wr_ptr_ff == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_ptr_ff + RQ_PTR_W'(1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_ptr_ff + RQ_PTR_W'(1);
      end
      if (put && !take) begin
         cnt_in = cnt_ff + RQ_CNT_W'(1);
      end else if (take && !put) begin
         cnt_in = cnt_ff - RQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
